// ----- rtl/rigid_body_2d_integrator_assert.svh -----
// ---------------------------------------------------------------------------
// Rigid body integrator assertion macros
// Concurrent assertion wrappers that compile away for synthesis.
// ---------------------------------------------------------------------------
`ifndef RIGID_BODY_2D_INTEGRATOR_ASSERT_SVH
`define RIGID_BODY_2D_INTEGRATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define RB2D_ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("rb2d assertion failed");
`define RB2D_ASSERT_NXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("rb2d assertion failed");
`else
`define RB2D_ASSERT_IMP(name, clk, rstn, ante, cons)
`define RB2D_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/rb2d_pkg.sv -----
// ---------------------------------------------------------------------------
// Rigid body integrator package
// Shared types, operation codes and saturation helpers.
// ---------------------------------------------------------------------------
package rb2d_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WIDE_W = 67;

	typedef enum logic [3:0] {
		OP_FORCE       = 4'd0,
		OP_FORCE_AT    = 4'd1,
		OP_TORQUE      = 4'd2,
		OP_IMPULSE     = 4'd3,
		OP_IMPULSE_AT  = 4'd4,
		OP_STEP        = 4'd5,
		OP_SLEEP_TICK  = 4'd6,
		OP_CORRECT     = 4'd7,
		OP_LOAD        = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		REG_INV_MASS    = 3'd0,
		REG_INV_INERTIA = 3'd1,
		REG_GRAV_SCALE  = 3'd2,
		REG_GRAV_EN     = 3'd3,
		REG_SLEEP_V2    = 3'd4,
		REG_SLEEP_W     = 3'd5,
		REG_SLEEP_TIME  = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	function automatic logic signed [31:0] sat_s32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sh0_0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -68'sh0_0000_0000_8000_0000)
			r = -32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] add_s32(input logic signed [31:0] a,
			input logic signed [32:0] b);
		return sat_s32(68'(a) + 68'(b));
	endfunction
endpackage

// ----- rtl/rb2d_mul.sv -----
// ---------------------------------------------------------------------------
// Rigid body shared multiplier
// Registered signed multiply with round-half-up rescale and saturation.
// ---------------------------------------------------------------------------
module rb2d_mul #(
	parameter int FRAC_BITS = rb2d_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic signed [32:0]                   a,
	input  logic signed [32:0]                   b,
	output logic signed [rb2d_pkg::WIDE_W-1:0]   wide,
	output logic signed [31:0]                   sat
);
	import rb2d_pkg::*;

	logic signed [65:0]       prod_s1;
	logic signed [WIDE_W-1:0] rnd;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	// Arithmetic shift floors, which with the added half gives round half up.
	assign rnd  = WIDE_W'(prod_s1) + (WIDE_W'(1) <<< (FRAC_BITS - 1));
	assign wide = rnd >>> FRAC_BITS;
	assign sat  = sat_s32(68'(wide));
endmodule

// ----- rtl/rigid_body_2d_integrator.sv -----
// ---------------------------------------------------------------------------
// Rigid body 2D integrator
// One fixed point rigid body: event accumulation, semi-implicit Euler step,
// sleep timing, pose correction and load, around one shared multiplier.
// ---------------------------------------------------------------------------
//  channel | signals                                  | handshake
//  in      | operation, value_*, aux_*, time_step     | in_valid / in_stall
//  out     | position_*, heading, speed_*, spin, asleep| out_valid / out_stall
//  cfg     | cfg_index, cfg_data                      | cfg_valid / cfg_ready
//
// A step sequences fourteen dependent products through the shared multiplier.
// An event at a point uses two products when the inverse inertia is nonzero, and a
// sleep tick uses two when the inverse mass is nonzero; other items use none.
// The multiplier has one register stage, so each product is used in the cycle after its operands are selected.
// The input stalls from acceptance until the result is in the output register.
// Reset clears the body state and loads register defaults; no clearing pass.
`include "rigid_body_2d_integrator_assert.svh"
module rigid_body_2d_integrator #(
	parameter int FRAC_BITS = rb2d_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         operation,
	input  logic signed [31:0] value_x,
	input  logic signed [31:0] value_y,
	input  logic signed [31:0] value_angle,
	input  logic signed [31:0] aux_x,
	input  logic signed [31:0] aux_y,
	input  logic signed [31:0] aux_angle,
	input  logic [16:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] position_x,
	output logic signed [31:0] position_y,
	output logic signed [31:0] heading,
	output logic signed [31:0] speed_x,
	output logic signed [31:0] speed_y,
	output logic signed [31:0] spin,
	output logic               asleep,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import rb2d_pkg::*;

	localparam logic [63:0] PI_Q32 = 64'd13493037705;
	localparam logic [63:0] PI_U = (PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	localparam logic signed [35:0] PI_Q = 36'(PI_U);
	localparam logic [3:0] CNT_STEP_LAST = 4'd14;
	localparam logic [3:0] CNT_PAIR_LAST = 4'd2;

	state_t state_q, state_d;
	logic [3:0] cnt_q, cnt_last;

	logic [31:0] inv_mass_q, inv_inertia_q, sleep_v2_q, sleep_time_q;
	logic signed [31:0] grav_scale_q;
	logic grav_en_q;
	logic [30:0] sleep_w_q;

	logic signed [31:0] pose_x_q, pose_y_q, pose_a_q, vel_x_q, vel_y_q, vel_a_q;
	logic signed [31:0] fsum_x_q, fsum_y_q, msum_q, isum_x_q, isum_y_q, imsum_q;
	logic [31:0] slow_timer_q;
	logic sleep_flag_q;

	op_t op_q;
	logic signed [31:0] vx_q, vy_q, va_q, ax_q, ay_q, aa_q;
	logic [16:0] dt_q;

	logic signed [WIDE_W-1:0] t1_q;
	logic signed [31:0] tmp_q, accx_q, accy_q, acca_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [WIDE_W-1:0] mul_wide;
	logic signed [31:0] mul_sat;

	logic signed [31:0] rx, ry;
	logic signed [32:0] dt_s, w_abs;
	logic signed [67:0] lin2;
	logic signed [35:0] ang;
	logic [32:0] timer_sum;
	logic [31:0] timer_sat;
	logic mass_nz, inertia_nz, accept, out_load, out_valid_q;

	rb2d_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.wide (mul_wide),
		.sat  (mul_sat)
	);

	assign mass_nz    = (inv_mass_q != 32'd0);
	assign inertia_nz = (inv_inertia_q != 32'd0);
	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign out_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;
	assign dt_s       = {16'd0, dt_q};

	assign rx = sat_s32(68'(ax_q) - 68'(pose_x_q));
	assign ry = sat_s32(68'(ay_q) - 68'(pose_y_q));
	assign lin2 = 68'(t1_q) + 68'(mul_wide);
	assign w_abs = vel_a_q[31] ? -33'(vel_a_q) : 33'(vel_a_q);
	assign ang = 36'(pose_a_q) + 36'(mul_sat);
	assign timer_sum = {1'b0, slow_timer_q} + {16'd0, dt_q};
	assign timer_sat = timer_sum[32] ? 32'hFFFF_FFFF : timer_sum[31:0];

	always_comb begin
		case (op_q)
			OP_STEP: cnt_last = CNT_STEP_LAST;
			OP_FORCE_AT, OP_IMPULSE_AT: cnt_last = inertia_nz ? CNT_PAIR_LAST : 4'd0;
			OP_SLEEP_TICK: cnt_last = mass_nz ? CNT_PAIR_LAST : 4'd0;
			default: cnt_last = 4'd0;
		endcase
	end

	// Operand select for the shared multiplier, at most one product per counter value.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_FORCE_AT, OP_IMPULSE_AT: begin
				if (cnt_q == 4'd0) begin
					mul_a = 33'(rx); mul_b = 33'(vy_q);
				end else begin
					mul_a = 33'(ry); mul_b = 33'(vx_q);
				end
			end
			OP_SLEEP_TICK: begin
				if (cnt_q == 4'd0) begin
					mul_a = 33'(vel_x_q); mul_b = 33'(vel_x_q);
				end else begin
					mul_a = 33'(vel_y_q); mul_b = 33'(vel_y_q);
				end
			end
			OP_STEP: begin
				case (cnt_q)
					4'd0: begin mul_a = 33'(isum_x_q); mul_b = {1'b0, inv_mass_q}; end
					4'd1: begin mul_a = 33'(isum_y_q); mul_b = {1'b0, inv_mass_q}; end
					4'd2: begin mul_a = 33'(imsum_q); mul_b = {1'b0, inv_inertia_q}; end
					4'd3: begin mul_a = 33'(fsum_x_q); mul_b = {1'b0, inv_mass_q}; end
					4'd4: begin mul_a = 33'(grav_scale_q); mul_b = 33'(vx_q); end
					4'd5: begin mul_a = 33'(fsum_y_q); mul_b = {1'b0, inv_mass_q}; end
					4'd6: begin mul_a = 33'(grav_scale_q); mul_b = 33'(vy_q); end
					4'd7: begin mul_a = 33'(msum_q); mul_b = {1'b0, inv_inertia_q}; end
					4'd8: begin mul_a = 33'(accx_q); mul_b = dt_s; end
					4'd9: begin mul_a = 33'(accy_q); mul_b = dt_s; end
					4'd10: begin mul_a = 33'(acca_q); mul_b = dt_s; end
					4'd11: begin mul_a = 33'(vel_x_q); mul_b = dt_s; end
					4'd12: begin mul_a = 33'(vel_y_q); mul_b = dt_s; end
					4'd13: begin mul_a = 33'(vel_a_q); mul_b = dt_s; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_RUN;
			ST_RUN:  if (cnt_q == cnt_last) state_d = ST_FIN;
			ST_FIN:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				cnt_q <= '0;
			else if (state_q == ST_RUN)
				cnt_q <= cnt_q + 4'd1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(operation);
			vx_q <= value_x; vy_q <= value_y; va_q <= value_angle;
			ax_q <= aux_x; ay_q <= aux_y; aa_q <= aux_angle;
			dt_q <= time_step;
		end
		if (state_q == ST_RUN) begin
			t1_q <= mul_wide;
			tmp_q <= mul_sat;
			if (op_q == OP_STEP) begin
				case (cnt_q)
					4'd5: accx_q <= grav_en_q ? add_s32(tmp_q, 33'(mul_sat)) : 32'sd0;
					4'd7: accy_q <= grav_en_q ? add_s32(tmp_q, 33'(mul_sat)) : 32'sd0;
					4'd8: acca_q <= inertia_nz ? mul_sat : 32'sd0;
					default: ;
				endcase
			end
		end
		if (out_load) begin
			position_x <= pose_x_q; position_y <= pose_y_q; heading <= pose_a_q;
			speed_x <= vel_x_q; speed_y <= vel_y_q; spin <= vel_a_q;
			asleep <= sleep_flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q <= '0; inv_inertia_q <= '0;
			grav_scale_q <= 32'sd65536; grav_en_q <= 1'b0;
			sleep_v2_q <= '0; sleep_w_q <= '0; sleep_time_q <= '0;
			pose_x_q <= '0; pose_y_q <= '0; pose_a_q <= '0;
			vel_x_q <= '0; vel_y_q <= '0; vel_a_q <= '0;
			fsum_x_q <= '0; fsum_y_q <= '0; msum_q <= '0;
			isum_x_q <= '0; isum_y_q <= '0; imsum_q <= '0;
			slow_timer_q <= '0; sleep_flag_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INV_MASS:    inv_mass_q <= cfg_data;
					REG_INV_INERTIA: inv_inertia_q <= cfg_data;
					REG_GRAV_SCALE:  grav_scale_q <= cfg_data;
					REG_GRAV_EN:     grav_en_q <= cfg_data[0];
					REG_SLEEP_V2:    sleep_v2_q <= cfg_data;
					REG_SLEEP_W:     sleep_w_q <= cfg_data[30:0];
					REG_SLEEP_TIME:  sleep_time_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_RUN) begin
				case (op_q)
					OP_FORCE, OP_FORCE_AT, OP_IMPULSE, OP_IMPULSE_AT: begin
						if (cnt_q == 4'd0) begin
							sleep_flag_q <= 1'b0;
							slow_timer_q <= '0;
							if (mass_nz) begin
								if (op_q == OP_FORCE || op_q == OP_FORCE_AT) begin
									fsum_x_q <= add_s32(fsum_x_q, 33'(vx_q));
									fsum_y_q <= add_s32(fsum_y_q, 33'(vy_q));
								end else begin
									isum_x_q <= add_s32(isum_x_q, 33'(vx_q));
									isum_y_q <= add_s32(isum_y_q, 33'(vy_q));
								end
							end
						end else if (cnt_q == CNT_PAIR_LAST) begin
							// Torque r x F from the two rounded products.
							if (op_q == OP_FORCE_AT)
								msum_q <= add_s32(msum_q,
									33'(sat_s32(68'(t1_q) - 68'(mul_wide))));
							else
								imsum_q <= add_s32(imsum_q,
									33'(sat_s32(68'(t1_q) - 68'(mul_wide))));
						end
					end
					OP_TORQUE: begin
						sleep_flag_q <= 1'b0;
						slow_timer_q <= '0;
						if (inertia_nz) msum_q <= add_s32(msum_q, 33'(va_q));
					end
					OP_STEP: begin
						case (cnt_q)
							4'd1: if (mass_nz) vel_x_q <= add_s32(vel_x_q, 33'(mul_sat));
							4'd2: if (mass_nz) vel_y_q <= add_s32(vel_y_q, 33'(mul_sat));
							4'd3: if (inertia_nz) vel_a_q <= add_s32(vel_a_q, 33'(mul_sat));
							4'd9:  vel_x_q <= add_s32(vel_x_q, 33'(mul_sat));
							4'd10: vel_y_q <= add_s32(vel_y_q, 33'(mul_sat));
							4'd11: vel_a_q <= add_s32(vel_a_q, 33'(mul_sat));
							4'd12: pose_x_q <= add_s32(pose_x_q, 33'(mul_sat));
							4'd13: pose_y_q <= add_s32(pose_y_q, 33'(mul_sat));
							4'd14: begin
								if (ang >= PI_Q)
									pose_a_q <= sat_s32(68'(ang - (PI_Q <<< 1)));
								else if (ang < -PI_Q)
									pose_a_q <= sat_s32(68'(ang + (PI_Q <<< 1)));
								else
									pose_a_q <= sat_s32(68'(ang));
								fsum_x_q <= '0; fsum_y_q <= '0; msum_q <= '0;
								isum_x_q <= '0; isum_y_q <= '0; imsum_q <= '0;
							end
							default: ;
						endcase
					end
					OP_SLEEP_TICK: begin
						if (!mass_nz) begin
							sleep_flag_q <= 1'b0;
							slow_timer_q <= '0;
						end else if (cnt_q == CNT_PAIR_LAST) begin
							if (lin2 < 68'({1'b0, sleep_v2_q}) && w_abs < {2'b0, sleep_w_q}) begin
								slow_timer_q <= timer_sat;
								if (timer_sat >= sleep_time_q) sleep_flag_q <= 1'b1;
							end else begin
								slow_timer_q <= '0;
							end
						end
					end
					OP_CORRECT: begin
						pose_x_q <= add_s32(pose_x_q, 33'(vx_q));
						pose_y_q <= add_s32(pose_y_q, 33'(vy_q));
						pose_a_q <= add_s32(pose_a_q, 33'(va_q));
					end
					OP_LOAD: begin
						pose_x_q <= vx_q; pose_y_q <= vy_q; pose_a_q <= va_q;
						vel_x_q <= ax_q; vel_y_q <= ay_q; vel_a_q <= aa_q;
					end
					default: ;
				endcase
			end
		end
	end

	`RB2D_ASSERT_NXT(a_accept_stalls, clk, arst_n, accept, in_stall)
	`RB2D_ASSERT_IMP(a_out_from_fin, clk, arst_n, $rose(out_valid), $past(state_q == ST_FIN))
	`RB2D_ASSERT_IMP(a_cnt_bound, clk, arst_n, state_q == ST_RUN, cnt_q <= CNT_STEP_LAST)
endmodule
